@@ src/b64kd_pkg.sv @@
// Shared types and constants for the base64 key decoder and validator.
// No dependencies; used by every module in src/.
package b64kd_pkg;

    localparam int KEY_TEXT_LEN = 44;   // characters in a canonical key text
    localparam int KEY_DIGITS   = 43;   // characters that carry digits
    localparam int KEY_BYTES    = 32;   // decoded key length
    localparam int POS_MAX      = 63;   // position counter saturates here

    localparam logic [7:0] CHAR_PAD   = 8'h3D;  // '='
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;  // '+'
    localparam logic [7:0] CHAR_SLASH = 8'h2F;  // '/'
    localparam logic [7:0] CHAR_UC_A  = 8'h41;  // 'A'
    localparam logic [7:0] CHAR_UC_Z  = 8'h5A;  // 'Z'
    localparam logic [7:0] CHAR_LC_A  = 8'h61;  // 'a'
    localparam logic [7:0] CHAR_LC_Z  = 8'h7A;  // 'z'
    localparam logic [7:0] CHAR_NUM_0 = 8'h30;  // '0'
    localparam logic [7:0] CHAR_NUM_9 = 8'h39;  // '9'

    localparam logic [5:0] DIGIT_LC_BASE  = 6'd26;
    localparam logic [5:0] DIGIT_NUM_BASE = 6'd52;
    localparam logic [5:0] DIGIT_PLUS     = 6'd62;
    localparam logic [5:0] DIGIT_SLASH    = 6'd63;

    typedef enum logic [2:0] {
        VERDICT_OK         = 3'd0,
        VERDICT_BAD_LENGTH = 3'd1,
        VERDICT_NO_PAD     = 3'd2,
        VERDICT_BAD_DIGIT  = 3'd3,
        VERDICT_SPARE_BITS = 3'd4,
        VERDICT_ALL_ZERO   = 3'd5
    } verdict_t;

    typedef struct packed {
        logic       legal;
        logic [5:0] value;
    } digit_t;

    typedef struct packed {
        logic       has_byte;
        logic [7:0] key_byte;
        logic       done_res;
        verdict_t   verdict;
    } result_t;

endpackage

@@ src/b64kd_digit_map.sv @@
// Base64 alphabet lookup: ASCII character to 6-bit digit plus legal flag.
// Depends on b64kd_pkg.
module b64kd_digit_map (
    input  logic [7:0]        character,
    output b64kd_pkg::digit_t digit
);

    always_comb begin
        digit.legal = 1'b1;
        digit.value = '0;
        if (character >= b64kd_pkg::CHAR_UC_A && character <= b64kd_pkg::CHAR_UC_Z) begin
            digit.value = 6'(character - b64kd_pkg::CHAR_UC_A);
        end else if (character >= b64kd_pkg::CHAR_LC_A
                     && character <= b64kd_pkg::CHAR_LC_Z) begin
            digit.value = 6'(character - b64kd_pkg::CHAR_LC_A) + b64kd_pkg::DIGIT_LC_BASE;
        end else if (character >= b64kd_pkg::CHAR_NUM_0
                     && character <= b64kd_pkg::CHAR_NUM_9) begin
            digit.value = 6'(character - b64kd_pkg::CHAR_NUM_0) + b64kd_pkg::DIGIT_NUM_BASE;
        end else if (character == b64kd_pkg::CHAR_PLUS) begin
            digit.value = b64kd_pkg::DIGIT_PLUS;
        end else if (character == b64kd_pkg::CHAR_SLASH) begin
            digit.value = b64kd_pkg::DIGIT_SLASH;
        end else begin
            digit.legal = 1'b0;   // shifted in as zero
        end
    end

endmodule

@@ src/b64kd_decode.sv @@
// Decode state and per-character step: bit packing, byte extraction, verdict.
// Depends on b64kd_pkg and b64kd_digit_map.
module b64kd_decode (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,        // consume the presented character
    input  logic [7:0]           character,
    input  logic                 last,
    output b64kd_pkg::result_t   result       // result for the presented character
);

    logic [5:0]  pos_reg, pos_next;
    logic [11:0] acc_reg, acc_next;
    logic [3:0]  pend_reg, pend_next;
    logic [5:0]  bytes_reg, bytes_next;
    logic        derr_reg, derr_next;
    logic        nz_reg, nz_next;

    b64kd_pkg::digit_t digit;
    logic [3:0]        pend_sum;
    logic [11:0]       acc_shifted;
    logic [7:0]        byte_val;
    logic              has_byte;
    logic [5:0]        count;

    b64kd_digit_map u_digit_map (
        .character (character),
        .digit     (digit)
    );

    always_comb begin
        acc_next    = acc_reg;
        pend_next   = pend_reg;
        bytes_next  = bytes_reg;
        derr_next   = derr_reg;
        nz_next     = nz_reg;
        has_byte    = 1'b0;
        byte_val    = '0;
        pend_sum    = pend_reg + 4'd6;
        acc_shifted = {acc_reg[5:0], digit.value};

        if (pos_reg < 6'(b64kd_pkg::KEY_DIGITS)) begin
            acc_next = acc_shifted;
            if (!digit.legal) begin
                derr_next = 1'b1;
            end
            if (pend_sum >= 4'd8) begin
                pend_next = pend_sum - 4'd8;
                byte_val  = 8'(acc_shifted >> pend_next);
                has_byte  = 1'b1;
                if (bytes_reg < 6'(b64kd_pkg::POS_MAX)) begin
                    bytes_next = bytes_reg + 6'd1;
                end
                if (byte_val != 8'd0) begin
                    nz_next = 1'b1;
                end
            end else begin
                pend_next = pend_sum;
            end
        end

        count = (pos_reg < 6'(b64kd_pkg::POS_MAX)) ? pos_reg + 6'd1 : pos_reg;
        pos_next = count;

        result.has_byte = has_byte;
        result.key_byte = byte_val;
        result.done_res = last;
        result.verdict  = b64kd_pkg::VERDICT_OK;
        if (last) begin
            if (count != 6'(b64kd_pkg::KEY_TEXT_LEN)) begin
                result.verdict = b64kd_pkg::VERDICT_BAD_LENGTH;
            end else if (character != b64kd_pkg::CHAR_PAD) begin
                result.verdict = b64kd_pkg::VERDICT_NO_PAD;
            end else if (derr_next) begin
                result.verdict = b64kd_pkg::VERDICT_BAD_DIGIT;
            end else if (bytes_next != 6'(b64kd_pkg::KEY_BYTES) || acc_next[1:0] != 2'b00) begin
                result.verdict = b64kd_pkg::VERDICT_SPARE_BITS;
            end else if (!nz_next) begin
                result.verdict = b64kd_pkg::VERDICT_ALL_ZERO;
            end
            // back to reset state after the verdict
            pos_next   = '0;
            acc_next   = '0;
            pend_next  = '0;
            bytes_next = '0;
            derr_next  = 1'b0;
            nz_next    = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            acc_reg   <= '0;
            pend_reg  <= '0;
            bytes_reg <= '0;
            derr_reg  <= 1'b0;
            nz_reg    <= 1'b0;
        end else if (step) begin
            pos_reg   <= pos_next;
            acc_reg   <= acc_next;
            pend_reg  <= pend_next;
            bytes_reg <= bytes_next;
            derr_reg  <= derr_next;
            nz_reg    <= nz_next;
        end
    end

    a_reset_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        step && last |=> pos_reg == 6'd0 && bytes_reg == 6'd0 && pend_reg == 4'd0)
        else $error("decode state not cleared after last character");

    a_pend_even: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg == 4'd0 || pend_reg == 4'd2 || pend_reg == 4'd4 || pend_reg == 4'd6)
        else $error("pending bit count out of range");

    a_bytes_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        bytes_reg <= 6'(b64kd_pkg::KEY_BYTES))
        else $error("more key bytes than a key holds");

    a_nonzero_needs_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        step && !last && $rose(nz_reg) == 1'b0 && !nz_reg |=> !nz_reg || $past(has_byte))
        else $error("nonzero flag set without a byte");

endmodule

@@ src/base64_key_decoder_validator_top.sv @@
// Top level of the base64 256-bit key decoder and validator.
// Depends on b64kd_pkg and b64kd_decode (which uses b64kd_digit_map).
//
//  channel  | dir | tdata                          | tuser     | tlast
//  ---------+-----+--------------------------------+-----------+----------
//  s_ (in)  | in  | [7:0] character                | -         | last char
//  m_ (out) | out | [7:0] key_byte, [10:8] verdict | has_byte  | done_res
//
// One character per cycle unless a result-producing character waits on a stalled
// result register; requests pass the input register, then the result register, to m_.
// A character that yields neither a byte nor a verdict produces no result.
// A stalled result register only blocks the input register when the waiting
// character would produce a result; decode state advances as each character
// leaves the input register. Reset (aresetn low, synchronous) empties both
// registers and clears the decode state; no clearing pass is needed.
module base64_key_decoder_validator_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] character
    input  logic        s_tlast,     // last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,     // [7:0] key_byte, [10:8] verdict, [15:11] zero
    output logic        m_tuser,     // has_byte
    output logic        m_tlast      // done_res
);

    // input register
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_char_reg;
    logic       in_last_reg;

    // result register
    logic                out_valid_reg, out_valid_next;
    b64kd_pkg::result_t  out_res_reg;

    b64kd_pkg::result_t  res;
    logic                produces;
    logic                advance;
    logic                out_free;

    b64kd_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .character (in_char_reg),
        .last      (in_last_reg),
        .result    (res)
    );

    // a request produces a result when it carries a byte or a verdict
    assign produces = res.has_byte || res.done_res;
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && (!produces || out_free);
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance && produces) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_char_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (advance && produces) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_res_reg.verdict, out_res_reg.key_byte};
    assign m_tuser  = out_res_reg.has_byte;
    assign m_tlast  = out_res_reg.done_res;

    a_no_empty_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tuser)
        else $error("result carries neither byte nor verdict");

    a_verdict_only_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tdata[10:8] == b64kd_pkg::VERDICT_OK)
        else $error("verdict set on a non-final result");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_tready |-> !(advance && produces))
        else $error("pending result overwritten");

endmodule

@@ verif/base64_key_decoder_validator_top_tb.sv @@
// Self-checking bench for base64_key_decoder_validator_top: key texts in, decoded bytes and
// verdicts out, compared against an in-bench decoder model.
// Depends on b64kd_pkg and the RTL under src/.
`timescale 1ns / 100ps

module base64_key_decoder_validator_top_tb;

    localparam int RANDOM_CHARS   = 550;
    localparam int HOLD_AT        = 1000;  // chars taken before the long receiver hold-off
    localparam int HOLD_LEN       = 400;
    localparam int WATCHDOG_LIMIT = 3000;  // cycles with no request moving on either side
    localparam int DRAIN_CYCLES   = 8;
    localparam int NUM_TEXTS      = 21;

    localparam string B64_ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    base64_key_decoder_validator_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Directed key texts: seed repeated to body_len chars, then tail; nul_at forces a NUL.
    // Only the verdict is typed in; bytes come from the decoder model.
    typedef struct {
        string               seed;
        int                  body_len;
        string               tail;
        int                  nul_at;
        b64kd_pkg::verdict_t verdict;
    } key_text_t;

    key_text_t key_texts [NUM_TEXTS] = '{
        '{"",           0,   "\377", -1, b64kd_pkg::VERDICT_BAD_LENGTH},  // 0xFF alone
        '{"",           0,   "A",    0,  b64kd_pkg::VERDICT_BAD_LENGTH},  // NUL alone
        '{"",           0,   "=",    -1, b64kd_pkg::VERDICT_BAD_LENGTH},
        '{"A",          2,   "=",    -1, b64kd_pkg::VERDICT_BAD_LENGTH},  // byte + verdict
        '{B64_ALPHABET, 42,  "w=",   -1, b64kd_pkg::VERDICT_OK},
        '{"/",          42,  "8=",   -1, b64kd_pkg::VERDICT_OK},          // all-ones bytes
        '{"+",          42,  "g=",   -1, b64kd_pkg::VERDICT_OK},
        '{"A",          43,  "=",    -1, b64kd_pkg::VERDICT_ALL_ZERO},
        '{"A",          42,  "B=",   -1, b64kd_pkg::VERDICT_SPARE_BITS},  // beats all-zero
        '{"/",          43,  "=",    -1, b64kd_pkg::VERDICT_SPARE_BITS},
        '{"A",          44,  "",     -1, b64kd_pkg::VERDICT_NO_PAD},
        '{"Q",          43,  "\377", -1, b64kd_pkg::VERDICT_NO_PAD},
        '{"QQQ=",       43,  "Q",    -1, b64kd_pkg::VERDICT_NO_PAD},      // beats bad digit
        '{"QQQ=",       43,  "=",    -1, b64kd_pkg::VERDICT_BAD_DIGIT},   // '=' in digits
        '{"Q",          43,  "=",    10, b64kd_pkg::VERDICT_BAD_DIGIT},   // NUL in digits
        '{"/",          43,  "=",    5,  b64kd_pkg::VERDICT_BAD_DIGIT},   // beats spare bits
        '{"Q",          42,  "=",    -1, b64kd_pkg::VERDICT_BAD_LENGTH},  // 43 chars
        '{"Q",          44,  "=",    -1, b64kd_pkg::VERDICT_BAD_LENGTH},  // 45 chars
        '{"Q",          107, "=",    -1, b64kd_pkg::VERDICT_BAD_LENGTH},  // 108, 44 if wrapped
        '{"AZaz09+/",   8,   "=",    -1, b64kd_pkg::VERDICT_BAD_LENGTH},  // legal range edges
        '{"@[{:,.-~",   8,   "=",    -1, b64kd_pkg::VERDICT_BAD_LENGTH}   // just outside
    };

    // Decoder model state
    logic [5:0]  key_pos           = '0;  // chars taken, saturates at POS_MAX
    logic [11:0] bit_buf           = '0;  // newest digit in the low bits
    logic [3:0]  buf_bits          = '0;  // bits in bit_buf not yet emitted
    logic [5:0]  key_len           = '0;  // bytes produced
    logic        bad_digit_seen    = 1'b0;
    logic        nonzero_byte_seen = 1'b0;

    b64kd_pkg::result_t exp_results [$];  // expected results, oldest first
    int      errors      = 0;
    int      chars_taken = 0;
    bit      quiet       = 1'b0;  // no random idle gaps on either side while set

    // Mostly short gaps, a few long ones, none while quiet.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic b64kd_pkg::digit_t to_digit(input logic [7:0] ch);
        b64kd_pkg::digit_t d;
        d.legal = 1'b1;
        d.value = '0;
        if (ch >= b64kd_pkg::CHAR_UC_A && ch <= b64kd_pkg::CHAR_UC_Z)
            d.value = 6'(ch - b64kd_pkg::CHAR_UC_A);
        else if (ch >= b64kd_pkg::CHAR_LC_A && ch <= b64kd_pkg::CHAR_LC_Z)
            d.value = 6'(ch - b64kd_pkg::CHAR_LC_A) + b64kd_pkg::DIGIT_LC_BASE;
        else if (ch >= b64kd_pkg::CHAR_NUM_0 && ch <= b64kd_pkg::CHAR_NUM_9)
            d.value = 6'(ch - b64kd_pkg::CHAR_NUM_0) + b64kd_pkg::DIGIT_NUM_BASE;
        else if (ch == b64kd_pkg::CHAR_PLUS)
            d.value = b64kd_pkg::DIGIT_PLUS;
        else if (ch == b64kd_pkg::CHAR_SLASH)
            d.value = b64kd_pkg::DIGIT_SLASH;
        else
            d.legal = 1'b0;
        return d;
    endfunction

    // Digit value to its text character, for building legal key texts.
    function automatic logic [7:0] b64_char(input logic [5:0] v);
        if (v < b64kd_pkg::DIGIT_LC_BASE)
            return b64kd_pkg::CHAR_UC_A + 8'(v);
        if (v < b64kd_pkg::DIGIT_NUM_BASE)
            return b64kd_pkg::CHAR_LC_A + 8'(v - b64kd_pkg::DIGIT_LC_BASE);
        if (v < b64kd_pkg::DIGIT_PLUS)
            return b64kd_pkg::CHAR_NUM_0 + 8'(v - b64kd_pkg::DIGIT_NUM_BASE);
        if (v == b64kd_pkg::DIGIT_PLUS)
            return b64kd_pkg::CHAR_PLUS;
        return b64kd_pkg::CHAR_SLASH;
    endfunction

    // Advances the model by one accepted char; got is set when the char yields a result.
    function automatic void decode_char(input logic [7:0] ch, input logic lst,
                                        output b64kd_pkg::result_t r, output bit got);
        b64kd_pkg::digit_t d;
        logic [5:0]        pos_next;
        r   = '0;
        got = 1'b0;
        if (key_pos < b64kd_pkg::KEY_DIGITS) begin
            d = to_digit(ch);
            if (!d.legal) bad_digit_seen = 1'b1;
            bit_buf  = {bit_buf[5:0], d.legal ? d.value : 6'd0};
            buf_bits = buf_bits + 4'd6;
            if (buf_bits >= 4'd8) begin
                buf_bits   = buf_bits - 4'd8;
                r.key_byte = 8'(bit_buf >> buf_bits);
                r.has_byte = 1'b1;
                if (key_len < b64kd_pkg::POS_MAX) key_len = key_len + 6'd1;
                if (r.key_byte != 8'd0) nonzero_byte_seen = 1'b1;
            end
        end
        pos_next = (key_pos < b64kd_pkg::POS_MAX) ? key_pos + 6'd1 : 6'(b64kd_pkg::POS_MAX);
        key_pos  = pos_next;
        got      = r.has_byte;
        if (lst) begin
            got        = 1'b1;
            r.done_res = 1'b1;
            if (pos_next != b64kd_pkg::KEY_TEXT_LEN)
                r.verdict = b64kd_pkg::VERDICT_BAD_LENGTH;
            else if (ch != b64kd_pkg::CHAR_PAD)
                r.verdict = b64kd_pkg::VERDICT_NO_PAD;
            else if (bad_digit_seen)
                r.verdict = b64kd_pkg::VERDICT_BAD_DIGIT;
            else if (key_len != b64kd_pkg::KEY_BYTES || bit_buf[1:0] != 2'b00)
                r.verdict = b64kd_pkg::VERDICT_SPARE_BITS;
            else if (!nonzero_byte_seen)
                r.verdict = b64kd_pkg::VERDICT_ALL_ZERO;
            else
                r.verdict = b64kd_pkg::VERDICT_OK;
            // verdict closes the key text: back to the reset state
            key_pos           = '0;
            bit_buf           = '0;
            buf_bits          = '0;
            key_len           = '0;
            bad_digit_seen    = 1'b0;
            nonzero_byte_seen = 1'b0;
        end
    endfunction

    // Sends one key text, the last char flagged; each request is modeled as it is taken.
    task automatic send_text(input logic [7:0] text [$], input bit typed,
                             input b64kd_pkg::verdict_t typed_v);
        b64kd_pkg::result_t r;
        bit      got;
        logic    lst;
        int      gap;
        foreach (text[i]) begin
            lst = (i == text.size() - 1);
            gap = idle_len();
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= text[i];
            s_tlast  <= lst;
            do @(posedge aclk); while (!s_tready);
            chars_taken++;
            decode_char(text[i], lst, r, got);
            if (got) begin
                if (typed && r.done_res) r.verdict = typed_v;
                exp_results.push_back(r);
            end
        end
    endtask

    function automatic void check_field(input string fname, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s expected %0h, got %0h", $time, fname, want, got);
            errors++;
        end
    endfunction

    // Result side: check each taken request, then pick the next ready level.
    b64kd_pkg::result_t rx_want;
    int      stall_left = 0;
    bit      hold_done  = 1'b0;

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (exp_results.size() == 0) begin
                $display("%0t: result with nothing pending, got tdata %h tuser %b tlast %b",
                         $time, m_tdata, m_tuser, m_tlast);
                errors++;
            end else begin
                rx_want = exp_results.pop_front();
                check_field("has_byte", rx_want.has_byte, m_tuser);
                check_field("key_byte", rx_want.key_byte, m_tdata[7:0]);
                check_field("done_res", rx_want.done_res, m_tlast);
                check_field("verdict",  rx_want.verdict,  m_tdata[10:8]);
            end
        end
        // one long hold-off so the pipe fills and backs up into s_tready
        if (!hold_done && chars_taken >= HOLD_AT) begin
            hold_done  = 1'b1;
            stall_left = HOLD_LEN;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            stall_left = ($urandom_range(0, 2) == 0) ? idle_len() : 0;
            m_tready <= (stall_left == 0);
        end
    end

    // Watchdog: ends the run if no request moves on either side for too long.
    int idle_cycles = 0;

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: timeout, %0d results pending", $time, exp_results.size());
                $display("base64_key_decoder_validator_top_tb: errors");
                $finish;
            end
        end
    end

    initial begin
        logic [7:0] txt [$];
        logic [5:0] v;
        int         rnd_chars;
        int         kind;
        int         n;
        rnd_chars = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // directed key texts
        foreach (key_texts[k]) begin
            txt.delete();
            for (int i = 0; i < key_texts[k].body_len; i++)
                txt.push_back(key_texts[k].seed[i % key_texts[k].seed.len()]);
            for (int i = 0; i < key_texts[k].tail.len(); i++)
                txt.push_back(key_texts[k].tail[i]);
            if (key_texts[k].nul_at >= 0) txt[key_texts[k].nul_at] = 8'h00;
            send_text(txt, 1'b1, key_texts[k].verdict);
        end

        // random part: mostly well-formed keys, some wrong lengths, corrupted and noise texts
        while (rnd_chars < RANDOM_CHARS) begin
            txt.delete();
            quiet = ($urandom_range(0, 4) == 0);
            kind  = $urandom_range(0, 99);
            if (kind < 90) begin
                n = b64kd_pkg::KEY_DIGITS;
                if (kind >= 70) n = $urandom_range(36, 50);
                if (kind >= 86) n = $urandom_range(55, 130);  // may run past the counter limit
                for (int i = 0; i < n; i++) begin
                    v = 6'($urandom_range(0, 63));
                    if (i == n - 1 && $urandom_range(0, 9) != 0) v[1:0] = 2'b00;
                    txt.push_back(b64_char(v));
                end
                txt.push_back(b64kd_pkg::CHAR_PAD);
                if ($urandom_range(0, 6) == 0)
                    txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom_range(0, 255));
            end else begin
                n = $urandom_range(1, 70);
                for (int i = 0; i < n; i++) txt.push_back(8'($urandom_range(0, 255)));
            end
            rnd_chars += txt.size();
            send_text(txt, 1'b0, b64kd_pkg::VERDICT_OK);
        end
        s_tvalid <= 1'b0;
        quiet = 1'b0;

        while (exp_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0 && exp_results.size() == 0)
            $display("base64_key_decoder_validator_top_tb: clean");
        else
            $display("base64_key_decoder_validator_top_tb: errors");
        $finish;
    end

endmodule
